// File: rtl/folded_phrase_line_matcher_defines.svh
// Assertion macros shared by the folded phrase line matcher RTL.
// No dependencies; included by the files that carry assertions.
`ifndef FOLDED_PHRASE_LINE_MATCHER_DEFINES_SVH
`define FOLDED_PHRASE_LINE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fpm_pkg.sv
// Shared types, constants and the byte folding function of the phrase line matcher.
// No dependencies.
package fpm_pkg;

    localparam int BYTE_W        = 8;
    localparam int LINE_W        = 32;
    localparam int LEN_CFG_W     = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int BYTES_PER_REG = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHRASE_LENGTH    = 3'd0,
        REG_PHRASE_BYTES_0   = 3'd1,
        REG_PHRASE_BYTES_8   = 3'd2,
        REG_PHRASE_BYTES_16  = 3'd3,
        REG_PHRASE_BYTES_24  = 3'd4
    } cfg_reg_e;

    localparam logic [BYTE_W-1:0] NEWLINE      = 8'h0A;
    localparam logic [BYTE_W-1:0] UPPER_A      = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z      = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [BYTE_W-1:0] LOWER_A      = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_E      = 8'h65;
    localparam logic [BYTE_W-1:0] LOWER_I      = 8'h69;
    localparam logic [BYTE_W-1:0] LOWER_O      = 8'h6F;
    localparam logic [BYTE_W-1:0] LOWER_U      = 8'h75;
    localparam logic [BYTE_W-1:0] LOWER_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] LAT_A_ACUTE  = 8'hE1;
    localparam logic [BYTE_W-1:0] LAT_A_ACUTE_U = 8'hC1;
    localparam logic [BYTE_W-1:0] LAT_E_ACUTE  = 8'hE9;
    localparam logic [BYTE_W-1:0] LAT_E_ACUTE_U = 8'hC9;
    localparam logic [BYTE_W-1:0] LAT_I_ACUTE  = 8'hED;
    localparam logic [BYTE_W-1:0] LAT_I_ACUTE_U = 8'hCD;
    localparam logic [BYTE_W-1:0] LAT_O_ACUTE  = 8'hF3;
    localparam logic [BYTE_W-1:0] LAT_O_ACUTE_U = 8'hD3;
    localparam logic [BYTE_W-1:0] LAT_U_ACUTE  = 8'hFA;
    localparam logic [BYTE_W-1:0] LAT_U_ACUTE_U = 8'hDA;
    localparam logic [BYTE_W-1:0] LAT_N_TILDE  = 8'hF1;
    localparam logic [BYTE_W-1:0] LAT_N_TILDE_U = 8'hD1;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic              phrase_found;
    } result_t;

    // Case and accent folding: ASCII capitals to lower case, Latin-1 accented
    // vowels and n-tilde to their plain lower case letters.
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] f;
        f = b;
        if (b >= UPPER_A && b <= UPPER_Z)
        begin
            f = b + CASE_OFFSET;
        end
        else
        begin
            case (b) inside
                LAT_A_ACUTE, LAT_A_ACUTE_U: f = LOWER_A;
                LAT_E_ACUTE, LAT_E_ACUTE_U: f = LOWER_E;
                LAT_I_ACUTE, LAT_I_ACUTE_U: f = LOWER_I;
                LAT_O_ACUTE, LAT_O_ACUTE_U: f = LOWER_O;
                LAT_U_ACUTE, LAT_U_ACUTE_U: f = LOWER_U;
                LAT_N_TILDE, LAT_N_TILDE_U: f = LOWER_N;
                default:                    f = b;
            endcase
        end
        return f;
    endfunction

endpackage

// File: rtl/fpm_channels.sv
// Valid/ready channel interfaces of the phrase line matcher: text, result, configuration.
// Depends on fpm_pkg for field widths.
interface fpm_text_if;
    logic                           valid;
    logic                           ready;
    logic [fpm_pkg::BYTE_W-1:0]     text_byte;
    logic                           end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface fpm_result_if;
    logic                           valid;
    logic                           ready;
    logic [fpm_pkg::LINE_W-1:0]     line_number;
    logic                           phrase_found;

    modport source (output valid, output line_number, output phrase_found, input ready);
    modport sink (input valid, input line_number, input phrase_found, output ready);
endinterface

interface fpm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fpm_pkg::CFG_INDEX_W-1:0]    index;
    logic [fpm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/folded_phrase_line_matcher.sv
// Top level of the folded phrase line matcher: line tracking, match window and result queue.
// Depends on fpm_pkg, the channel interfaces, fpm_phrase and the assertion macro header.
//
//   Channel  Dir  Payload                          Beat completes when
//   text     in   text_byte[8], end_of_text[1]     text.valid && text.ready
//   result   out  line_number[32], phrase_found[1] result.valid && result.ready
//   cfg      in   index[3], data[64]               cfg.valid && cfg.ready
//
// One text beat is taken per cycle while text.ready is high; a line result is registered in
// the result register, or in the one skid entry while that register is held; the two decouple
// the sides. text.ready drops while the skid entry is occupied, and in the cycle after a cfg
// beat while the pattern is realigned. Reset clears control state only; cfg.ready is always high.
`include "folded_phrase_line_matcher_defines.svh"

module folded_phrase_line_matcher #(
    parameter int PHRASE_MAX = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    fpm_text_if.sink      text,
    fpm_result_if.source  result,
    fpm_cfg_if.sink       cfg
);
    localparam int FILL_W = $clog2(PHRASE_MAX + 1);
    localparam int BW     = fpm_pkg::BYTE_W;
    localparam int LW     = fpm_pkg::LINE_W;

    logic [PHRASE_MAX*BW-1:0]      pattern;
    logic [PHRASE_MAX-1:0]         mask;
    logic [FILL_W-1:0]             used_len;
    logic                          cfg_busy;

    logic [PHRASE_MAX-1:0][BW-1:0] window_reg, window_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic                          active_reg, active_next;
    logic                          seen_reg, seen_next;
    logic [LW-1:0]                 line_cnt_reg, line_cnt_next;
    fpm_pkg::result_t              out_reg, out_next, skid_reg, skid_next, res;
    logic                          out_valid_reg, out_valid_next;
    logic                          skid_valid_reg, skid_valid_next;

    logic                          in_fire, pop, push, is_newline, line_end, hit;
    logic [FILL_W-1:0]             fill_inc;
    logic [PHRASE_MAX-1:0]         slot_ok;

    fpm_phrase #(
        .PHRASE_MAX (PHRASE_MAX)
    ) u_phrase (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pattern  (pattern),
        .mask     (mask),
        .used_len (used_len),
        .busy     (cfg_busy)
    );

    assign text.ready = !skid_valid_reg && !cfg_busy;
    assign in_fire    = text.valid && text.ready;
    assign pop        = out_valid_reg && result.ready;
    assign is_newline = text.text_byte == fpm_pkg::NEWLINE;
    assign line_end   = is_newline || text.end_of_text;

    always_comb
    begin
        window_next[0] = fpm_pkg::fold_byte(text.text_byte);
        for (int s = 1; s < PHRASE_MAX; s++)
        begin
            window_next[s] = window_reg[s-1];
        end
        fill_inc = (fill_reg == FILL_W'(PHRASE_MAX)) ? fill_reg : fill_reg + 1'b1;
        for (int s = 0; s < PHRASE_MAX; s++)
        begin
            slot_ok[s] = !mask[s] || (window_next[s] == pattern[s*BW +: BW]);
        end
        hit = (&slot_ok) && (fill_inc >= used_len);
    end

    always_comb
    begin
        fill_next     = fill_reg;
        active_next   = active_reg;
        seen_next     = seen_reg;
        line_cnt_next = line_cnt_reg;
        push          = 1'b0;
        if (in_fire)
        begin
            if (!is_newline)
            begin
                fill_next   = fill_inc;
                active_next = 1'b1;
                seen_next   = seen_reg || hit;
            end
            if (line_end)
            begin
                push = active_next;
                if (active_next && line_cnt_reg != {LW{1'b1}})
                begin
                    line_cnt_next = line_cnt_reg + 1'b1;
                end
                if (text.end_of_text)
                begin
                    line_cnt_next = '0;
                end
                fill_next   = '0;
                active_next = 1'b0;
                seen_next   = 1'b0;
            end
        end
        res.line_number  = line_cnt_reg;
        res.phrase_found = (!is_newline && hit) || seen_reg;
    end

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            active_reg     <= 1'b0;
            seen_reg       <= 1'b0;
            line_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            active_reg     <= active_next;
            seen_reg       <= seen_next;
            line_cnt_reg   <= line_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !is_newline)
        begin
            window_reg <= window_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.line_number  = out_reg.line_number;
    assign result.phrase_found = out_reg.phrase_found;

    `FPM_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry holds a result while the output register is empty")
    `FPM_ASSERT_NXT(a_cfg_settle, clk, rst_n, cfg.valid && cfg.ready, !text.ready,
        "text accepted in the cycle after a configuration beat")
    `FPM_ASSERT_IMP(a_idle_line_clear, clk, rst_n, !active_reg,
        fill_reg == '0 && !seen_reg, "empty line carries window fill or a match")
    `FPM_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(PHRASE_MAX),
        "window fill exceeds the phrase capacity")

endmodule

// File: rtl/fpm_phrase.sv
// Phrase configuration registers and the aligned, folded compare pattern built from them.
// Depends on fpm_pkg and fpm_cfg_if.
module fpm_phrase #(
    parameter int PHRASE_MAX = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    fpm_cfg_if.sink                              cfg,
    output logic [PHRASE_MAX*fpm_pkg::BYTE_W-1:0] pattern,
    output logic [PHRASE_MAX-1:0]                mask,
    output logic [$clog2(PHRASE_MAX+1)-1:0]      used_len,
    output logic                                 busy
);
    localparam int FILL_W    = $clog2(PHRASE_MAX + 1);
    localparam int BW        = fpm_pkg::BYTE_W;
    localparam int REG_BYTES = fpm_pkg::BYTES_PER_REG;
    localparam int SH_W      = $clog2(PHRASE_MAX * BW + 1);

    logic [fpm_pkg::LEN_CFG_W-1:0]     len_reg, len_next;
    logic [PHRASE_MAX-1:0][BW-1:0]     phrase_reg, phrase_next;
    logic [PHRASE_MAX*BW-1:0]          pattern_reg, pattern_next;
    logic [PHRASE_MAX-1:0]             mask_reg, mask_next;
    logic [FILL_W-1:0]                 used_len_reg, used_len_next;
    logic                              settle_reg;
    logic                              cfg_fire;
    logic [PHRASE_MAX*BW-1:0]          reversed;
    logic [SH_W-1:0]                   shift_amt;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        len_next    = len_reg;
        phrase_next = phrase_reg;
        if (cfg_fire)
        begin
            unique case (fpm_pkg::cfg_reg_e'(cfg.index))
                fpm_pkg::REG_PHRASE_LENGTH:
                begin
                    len_next = cfg.data[fpm_pkg::LEN_CFG_W-1:0];
                end
                fpm_pkg::REG_PHRASE_BYTES_0, fpm_pkg::REG_PHRASE_BYTES_8,
                fpm_pkg::REG_PHRASE_BYTES_16, fpm_pkg::REG_PHRASE_BYTES_24:
                begin
                    for (int p = 0; p < PHRASE_MAX; p++)
                    begin
                        if (int'(cfg.index) == (p / REG_BYTES) + 1)
                        begin
                            phrase_next[p] = cfg.data[BW*(p % REG_BYTES) +: BW];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The pattern holds phrase byte len-1-s in slot s, so slot 0 meets the newest text byte.
    always_comb
    begin
        if (int'(len_reg) > PHRASE_MAX)
        begin
            used_len_next = FILL_W'(PHRASE_MAX);
        end
        else
        begin
            used_len_next = FILL_W'(len_reg);
        end
        for (int s = 0; s < PHRASE_MAX; s++)
        begin
            reversed[s*BW +: BW] = fpm_pkg::fold_byte(phrase_reg[PHRASE_MAX-1-s]);
            mask_next[s]         = FILL_W'(s) < used_len_next;
        end
        shift_amt    = SH_W'((PHRASE_MAX - int'(used_len_next)) * BW);
        pattern_next = reversed >> shift_amt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            phrase_reg   <= '0;
            pattern_reg  <= '0;
            mask_reg     <= '0;
            used_len_reg <= '0;
            settle_reg   <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            phrase_reg   <= phrase_next;
            pattern_reg  <= pattern_next;
            mask_reg     <= mask_next;
            used_len_reg <= used_len_next;
            settle_reg   <= cfg_fire;
        end
    end

    assign pattern  = pattern_reg;
    assign mask     = mask_reg;
    assign used_len = used_len_reg;
    assign busy     = settle_reg;

endmodule
